// ----- design/ncpe_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the NURBS curve point evaluator.
// No dependencies; used by every other file of the block.
package ncpe_pkg;

   localparam int MAX_POINTS = 16;
   localparam int MAX_DEGREE = 3;
   localparam int MAX_KNOTS  = 32;

   localparam int PT_AW    = $clog2(MAX_POINTS);
   localparam int KNOT_AW  = $clog2(MAX_KNOTS);
   localparam int BASIS_N  = MAX_POINTS + MAX_DEGREE;
   localparam int BIDX_W   = $clog2(BASIS_N + 1);
   localparam int DEG_W    = 2;
   localparam int CNT_W    = 5;
   localparam int CSR_W    = 5;
   localparam int DIV_QW   = 31;
   localparam int ACC_W    = 62;

   localparam logic signed [63:0] RND30 = 64'sh0000_0000_3FFF_FFFF;
   localparam logic signed [63:0] RND22 = 64'sh0000_0000_003F_FFFF;
   localparam logic signed [31:0] Q30_ONE = 32'sh4000_0000;
   localparam logic [17:0] W_ONE = 18'h10000;

   typedef enum logic [1:0] {
      FUNC_KNOT  = 2'd0,
      FUNC_POINT = 2'd1,
      FUNC_EVAL  = 2'd2,
      FUNC_NONE  = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_WSUM  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef enum logic [0:0] {
      CSR_DEGREE = 1'b0,
      CSR_COUNT  = 1'b1
   } csr_idx_type;

   typedef enum logic [1:0] {
      AX_X = 2'd0,
      AX_Y = 2'd1,
      AX_Z = 2'd2
   } axis_type;

   typedef enum logic [4:0] {
      OP_NOP, OP_WRITE, OP_LOAD_U, OP_ZERO, OP_CAP_LO, OP_CAP_HI, OP_CLAMP,
      OP_CAP_KA, OP_CAP_KB, OP_CAP_KC, OP_CAP_KD, OP_LVL0, OP_CLR_SUM,
      OP_DIV_L, OP_DIV_R, OP_MUL_L, OP_MUL_R, OP_ADD, OP_STEP,
      OP_WB, OP_BW, OP_PMUL, OP_PACC, OP_DIV_F, OP_SET_F, OP_FALLBACK
   } dp_op_type;

   typedef struct packed {
      logic [1:0]         func;
      logic [4:0]         entry_index;
      logic signed [31:0] knot_value;
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic signed [31:0] point_z;
      logic [17:0]        point_weight;
      logic signed [31:0] param_u;
   } req_type;

   typedef struct packed {
      logic signed [31:0] curve_x;
      logic signed [31:0] curve_y;
      logic signed [31:0] curve_z;
      logic [1:0]         eval_status;
   } rsp_type;

   typedef struct packed {
      dp_op_type          op;
      logic [KNOT_AW-1:0] knot_addr;
      logic [PT_AW-1:0]   pt_addr;
      axis_type           axis;
   } dp_cmd_type;

   typedef struct packed {
      logic dl_zero;
      logic dr_zero;
      logic den_pos;
      logic div_busy;
   } dp_stat_type;

endpackage

// ----- design/ncpe_div.sv -----
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, 31-bit quotient.
// Uses ncpe_pkg. Flags a quotient of 2^31 or more as saturated up front.
module ncpe_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [33:0] divisor,
   output logic        busy,
   output logic [ncpe_pkg::DIV_QW-1:0] quo,
   output logic        sat
);
   import ncpe_pkg::*;

   logic              busy_ff, busy_in;
   logic [4:0]        cnt_ff, cnt_in;
   logic [33:0]       rem_ff, rem_in;
   logic [30:0]       low_ff, low_in;
   logic [33:0]       dsr_ff, dsr_in;
   logic [DIV_QW-1:0] quo_ff, quo_in;
   logic              sat_ff, sat_in;
   logic [34:0]       trial, diff;
   logic              ge;

   always_comb begin
      trial   = {rem_ff, low_ff[30]};
      diff    = trial - {1'b0, dsr_ff};
      ge      = trial >= {1'b0, dsr_ff};
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      low_in  = low_ff;
      dsr_in  = dsr_ff;
      quo_in  = quo_ff;
      sat_in  = sat_ff;
      if (start) begin
         // quotient won't fit in 31 bits when dividend >= divisor * 2^31
         sat_in  = {1'b0, dividend} >= {divisor, 31'b0};
         busy_in = !sat_in;
         rem_in  = {1'b0, dividend[63:31]};
         low_in  = dividend[30:0];
         dsr_in  = divisor;
         quo_in  = '0;
         cnt_in  = 5'(DIV_QW);
      end else if (busy_ff) begin
         rem_in  = ge ? diff[33:0] : trial[33:0];
         low_in  = {low_ff[29:0], 1'b0};
         quo_in  = {quo_ff[DIV_QW-2:0], ge};
         cnt_in  = cnt_ff - 5'd1;
         busy_in = cnt_ff != 5'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      low_ff <= low_in;
      dsr_ff <= dsr_in;
      quo_ff <= quo_in;
      sat_ff <= sat_in;
   end

   assign busy = busy_ff;
   assign quo  = quo_ff;
   assign sat  = sat_ff;

endmodule

// ----- design/ncpe_dp.sv -----
`timescale 1ns / 1ps
// Datapath: tables, basis shift line, multipliers, accumulators, result register.
// Uses ncpe_pkg and ncpe_div; driven by ncpe_ctrl through dp_cmd_type.
module ncpe_dp (
   input  logic                 clock,
   input  logic                 reset,
   input  ncpe_pkg::req_type    req,
   input  ncpe_pkg::dp_cmd_type cmd,
   output ncpe_pkg::dp_stat_type stat,
   output ncpe_pkg::rsp_type    rsp
);
   import ncpe_pkg::*;

   // storage
   logic signed [31:0] knot_mem [MAX_KNOTS];
   logic signed [31:0] px_mem   [MAX_POINTS];
   logic signed [31:0] py_mem   [MAX_POINTS];
   logic signed [31:0] pz_mem   [MAX_POINTS];
   logic [17:0]        wt_mem   [MAX_POINTS];
   logic [MAX_POINTS-1:0] wt_vld_ff;

   logic signed [31:0] knot_rd_ff, prx_ff, pry_ff, prz_ff;
   logic [17:0]        prw_ff;

   logic signed [32:0] u_ff, u_in, hi_ff, hi_in;
   logic signed [31:0] lo_ff, lo_in;
   logic signed [31:0] ka_ff, ka_in, kb_ff, kb_in, kc_ff, kc_in, kd_ff, kd_in;
   logic signed [31:0] sr_ff [BASIS_N];
   logic signed [31:0] sr_new;
   logic               sr_shift;
   logic signed [33:0] sum_ff, sum_in;
   logic signed [63:0] prod_ff, prod_in;
   logic signed [27:0] bw_ff, bw_in;
   logic signed [59:0] mx_ff, mx_in, my_ff, my_in, mz_ff, mz_in;
   logic signed [ACC_W-1:0] ax_ff, ax_in, ay_ff, ay_in, az_ff, az_in;
   logic signed [31:0] den_ff, den_in;
   logic               neg_ff, neg_in;
   rsp_type            rsp_ff, rsp_in;

   // arithmetic
   logic signed [32:0] dl, dr;
   logic signed [33:0] num_l, num_r;
   logic [33:0]        anum_l, anum_r;
   logic [32:0]        adl, adr;
   logic signed [ACC_W-1:0] acc_sel;
   logic [ACC_W-1:0]   aacc;
   logic               div_start, div_busy, div_sat;
   logic [DIV_QW-1:0]  div_quo;
   logic [63:0]        div_dvd;
   logic [33:0]        div_dsr;
   logic [31:0]        rmag;
   logic signed [32:0] ratio;
   logic signed [64:0] mul_rb;
   logic signed [63:0] adj30, adj22, sh30, sh22;
   logic signed [31:0] fval;
   logic signed [48:0] mul_wb;

   always_comb begin
      dl     = 33'(kb_ff) - 33'(ka_ff);
      dr     = 33'(kd_ff) - 33'(kc_ff);
      num_l  = 34'(u_ff) - 34'(ka_ff);
      num_r  = 34'(kd_ff) - 34'(u_ff);
      anum_l = num_l[33] ? 34'(-num_l) : 34'(num_l);
      anum_r = num_r[33] ? 34'(-num_r) : 34'(num_r);
      adl    = dl[32] ? 33'(-dl) : 33'(dl);
      adr    = dr[32] ? 33'(-dr) : 33'(dr);
      unique case (cmd.axis)
         AX_X:    acc_sel = ax_ff;
         AX_Y:    acc_sel = ay_ff;
         AX_Z:    acc_sel = az_ff;
         default: acc_sel = az_ff;
      endcase
      aacc = acc_sel[ACC_W-1] ? ACC_W'(-acc_sel) : ACC_W'(acc_sel);

      div_start = 1'b0;
      div_dvd   = {anum_l, 30'b0};
      div_dsr   = {1'b0, adl};
      unique case (cmd.op)
         OP_DIV_L: begin
            div_start = 1'b1;
         end
         OP_DIV_R: begin
            div_start = 1'b1;
            div_dvd   = {anum_r, 30'b0};
            div_dsr   = {1'b0, adr};
         end
         OP_DIV_F: begin
            div_start = 1'b1;
            div_dvd   = 64'(aacc);
            div_dsr   = 34'(unsigned'(den_ff));
         end
         default: ;
      endcase

      // span ratio in Q.30, saturated at 2.0
      rmag   = div_sat ? 32'h8000_0000 : {1'b0, div_quo};
      ratio  = neg_ff ? -$signed({1'b0, rmag}) : $signed({1'b0, rmag});
      mul_rb = ratio * ((cmd.op == OP_MUL_R) ? sr_ff[1] : sr_ff[0]);
      mul_wb = sr_ff[0] * $signed({1'b0, prw_ff});

      // truncation toward zero for the fixed-point rescales
      adj30 = prod_ff + (prod_ff[63] ? RND30 : 64'sd0);
      adj22 = prod_ff + (prod_ff[63] ? RND22 : 64'sd0);
      sh30  = adj30 >>> 30;
      sh22  = adj22 >>> 22;

      if (neg_ff)
         fval = div_sat ? 32'sh8000_0000 : -$signed({1'b0, div_quo});
      else
         fval = div_sat ? 32'sh7FFF_FFFF : $signed({1'b0, div_quo});
   end

   ncpe_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (div_dsr),
      .busy     (div_busy),
      .quo      (div_quo),
      .sat      (div_sat)
   );

   always_comb begin
      u_in     = u_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      ka_in    = ka_ff;
      kb_in    = kb_ff;
      kc_in    = kc_ff;
      kd_in    = kd_ff;
      sum_in   = sum_ff;
      prod_in  = prod_ff;
      bw_in    = bw_ff;
      mx_in    = mx_ff;
      my_in    = my_ff;
      mz_in    = mz_ff;
      ax_in    = ax_ff;
      ay_in    = ay_ff;
      az_in    = az_ff;
      den_in   = den_ff;
      neg_in   = neg_ff;
      rsp_in   = rsp_ff;
      sr_shift = 1'b0;
      sr_new   = '0;
      unique case (cmd.op)
         OP_LOAD_U: u_in  = 33'(req.param_u);
         OP_ZERO: begin
            rsp_in.curve_x     = '0;
            rsp_in.curve_y     = '0;
            rsp_in.curve_z     = '0;
            rsp_in.eval_status = ST_EMPTY;
         end
         OP_CAP_LO: lo_in = knot_rd_ff;
         OP_CAP_HI: hi_in = 33'(knot_rd_ff) - 33'sd1;
         OP_CLAMP: begin
            // hi first, then lo: an empty range lands on the first knot
            if (u_ff > hi_ff) begin
               u_in = (hi_ff < 33'(lo_ff)) ? 33'(lo_ff) : hi_ff;
            end else if (u_ff < 33'(lo_ff)) begin
               u_in = 33'(lo_ff);
            end
            ax_in  = '0;
            ay_in  = '0;
            az_in  = '0;
            den_in = '0;
         end
         OP_CAP_KA: ka_in = knot_rd_ff;
         OP_CAP_KB: kb_in = knot_rd_ff;
         OP_CAP_KC: kc_in = knot_rd_ff;
         OP_CAP_KD: kd_in = knot_rd_ff;
         OP_LVL0: begin
            sr_shift = 1'b1;
            sr_new   = (u_ff >= 33'(ka_ff) && u_ff < 33'(kc_ff)) ? Q30_ONE : 32'sd0;
         end
         OP_CLR_SUM: sum_in = '0;
         OP_DIV_L:   neg_in = num_l[33] != dl[32];
         OP_DIV_R:   neg_in = num_r[33] != dr[32];
         OP_DIV_F:   neg_in = acc_sel[ACC_W-1];
         OP_MUL_L,
         OP_MUL_R:   prod_in = mul_rb[63:0];
         OP_ADD:     sum_in  = sum_ff + $signed(sh30[33:0]);
         OP_STEP: begin
            sr_shift = 1'b1;
            if (sum_ff > 34'(Q30_ONE))
               sr_new = Q30_ONE;
            else if (sum_ff < -34'(Q30_ONE))
               sr_new = -Q30_ONE;
            else
               sr_new = sum_ff[31:0];
         end
         OP_WB:   prod_in = 64'(mul_wb);
         OP_BW:   bw_in   = sh22[27:0];
         OP_PMUL: begin
            mx_in = prx_ff * bw_ff;
            my_in = pry_ff * bw_ff;
            mz_in = prz_ff * bw_ff;
         end
         OP_PACC: begin
            ax_in    = ax_ff + ACC_W'(mx_ff);
            ay_in    = ay_ff + ACC_W'(my_ff);
            az_in    = az_ff + ACC_W'(mz_ff);
            den_in   = den_ff + 32'(bw_ff);
            sr_shift = 1'b1;
         end
         OP_SET_F: begin
            rsp_in.eval_status = ST_OK;
            unique case (cmd.axis)
               AX_X:    rsp_in.curve_x = fval;
               AX_Y:    rsp_in.curve_y = fval;
               AX_Z:    rsp_in.curve_z = fval;
               default: ;
            endcase
         end
         OP_FALLBACK: begin
            rsp_in.curve_x     = prx_ff;
            rsp_in.curve_y     = pry_ff;
            rsp_in.curve_z     = prz_ff;
            rsp_in.eval_status = ST_WSUM;
         end
         default: ;
      endcase
   end

   // tables: written only from idle, read registered
   always_ff @(posedge clock) begin
      if (cmd.op == OP_WRITE && req.func == FUNC_KNOT)
         knot_mem[req.entry_index[KNOT_AW-1:0]] <= req.knot_value;
      if (cmd.op == OP_WRITE && req.func == FUNC_POINT && req.entry_index < 5'(MAX_POINTS)) begin
         px_mem[req.entry_index[PT_AW-1:0]] <= req.point_x;
         py_mem[req.entry_index[PT_AW-1:0]] <= req.point_y;
         pz_mem[req.entry_index[PT_AW-1:0]] <= req.point_z;
         wt_mem[req.entry_index[PT_AW-1:0]] <= req.point_weight;
      end
      knot_rd_ff <= knot_mem[cmd.knot_addr];
      prx_ff     <= px_mem[cmd.pt_addr];
      pry_ff     <= py_mem[cmd.pt_addr];
      prz_ff     <= pz_mem[cmd.pt_addr];
      prw_ff     <= wt_vld_ff[cmd.pt_addr] ? wt_mem[cmd.pt_addr] : W_ONE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wt_vld_ff <= '0;
      end else if (cmd.op == OP_WRITE && req.func == FUNC_POINT &&
                   req.entry_index < 5'(MAX_POINTS)) begin
         wt_vld_ff[req.entry_index[PT_AW-1:0]] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      u_ff    <= u_in;
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      ka_ff   <= ka_in;
      kb_ff   <= kb_in;
      kc_ff   <= kc_in;
      kd_ff   <= kd_in;
      sum_ff  <= sum_in;
      prod_ff <= prod_in;
      bw_ff   <= bw_in;
      mx_ff   <= mx_in;
      my_ff   <= my_in;
      mz_ff   <= mz_in;
      ax_ff   <= ax_in;
      ay_ff   <= ay_in;
      az_ff   <= az_in;
      den_ff  <= den_in;
      neg_ff  <= neg_in;
      rsp_ff  <= rsp_in;
   end

   // basis line: head and next are the only taps, new values enter at the tail
   always_ff @(posedge clock) begin
      if (sr_shift) begin
         for (int k = 0; k < BASIS_N - 1; k++)
            sr_ff[k] <= sr_ff[k+1];
         sr_ff[BASIS_N-1] <= sr_new;
      end
   end

   assign stat.dl_zero  = kb_ff == ka_ff;
   assign stat.dr_zero  = kd_ff == kc_ff;
   assign stat.den_pos  = !den_ff[31] && den_ff != 32'sd0;
   assign stat.div_busy = div_busy;
   assign rsp           = rsp_ff;

endmodule

// ----- design/ncpe_ctrl.sv -----
`timescale 1ns / 1ps
// Sequencer: config registers, item handshake and the evaluation schedule.
// Uses ncpe_pkg; issues dp_cmd_type to ncpe_dp and reads dp_stat_type back.
module ncpe_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  ncpe_pkg::req_type     req,
   output logic                  busy,
   output logic                  rsp_valid,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [0:0]            csr_index,
   input  logic [ncpe_pkg::CSR_W-1:0] csr_wdata,
   output ncpe_pkg::dp_cmd_type  cmd,
   input  ncpe_pkg::dp_stat_type stat
);
   import ncpe_pkg::*;

   typedef enum logic [26:0] {
      S_IDLE  = 27'b1 << 0,
      S_LO    = 27'b1 << 1,
      S_HI    = 27'b1 << 2,
      S_CLAMP = 27'b1 << 3,
      S_RA    = 27'b1 << 4,
      S_RB    = 27'b1 << 5,
      S_RC    = 27'b1 << 6,
      S_RD    = 27'b1 << 7,
      S_RE    = 27'b1 << 8,
      S_LV0   = 27'b1 << 9,
      S_CLR   = 27'b1 << 10,
      S_DIVL  = 27'b1 << 11,
      S_WL    = 27'b1 << 12,
      S_AL    = 27'b1 << 13,
      S_DIVR  = 27'b1 << 14,
      S_WR    = 27'b1 << 15,
      S_AR    = 27'b1 << 16,
      S_STEP  = 27'b1 << 17,
      S_PA    = 27'b1 << 18,
      S_PB    = 27'b1 << 19,
      S_PC    = 27'b1 << 20,
      S_PD    = 27'b1 << 21,
      S_PE    = 27'b1 << 22,
      S_FIN   = 27'b1 << 23,
      S_FB    = 27'b1 << 24,
      S_DF    = 27'b1 << 25,
      S_WF    = 27'b1 << 26
   } state_type;

   state_type         state_ff, state_in;
   logic [BIDX_W-1:0] j_ff, j_in;
   logic [DEG_W-1:0]  q_ff, q_in;
   axis_type          ax_ff, ax_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DEG_W-1:0]  deg_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [CNT_W-1:0]  n_eff;
   logic [DEG_W-1:0]  p_eff;
   logic              last_step;

   function automatic logic [KNOT_AW-1:0] kidx(input logic [6:0] v);
      return (v > 7'(MAX_KNOTS - 1)) ? KNOT_AW'(MAX_KNOTS - 1) : v[KNOT_AW-1:0];
   endfunction

   assign n_eff = (cnt_ff > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : cnt_ff;
   assign p_eff = (deg_ff > DEG_W'(MAX_DEGREE)) ? DEG_W'(MAX_DEGREE) : deg_ff;
   assign last_step = j_ff == BIDX_W'(BASIS_N - 1);

   always_comb begin
      state_in      = state_ff;
      j_in          = j_ff;
      q_in          = q_ff;
      ax_in         = ax_ff;
      rsp_valid_in  = 1'b0;
      cmd.op        = OP_NOP;
      cmd.knot_addr = '0;
      cmd.pt_addr   = j_ff[PT_AW-1:0];
      cmd.axis      = ax_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               unique case (req.func)
                  FUNC_KNOT,
                  FUNC_POINT: cmd.op = OP_WRITE;
                  FUNC_EVAL: begin
                     if (n_eff == '0) begin
                        cmd.op       = OP_ZERO;
                        rsp_valid_in = 1'b1;
                     end else begin
                        cmd.op   = OP_LOAD_U;
                        state_in = S_LO;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_LO: begin
            cmd.op        = OP_CAP_LO;
            cmd.knot_addr = kidx(7'(n_eff) + 7'(p_eff));
            state_in      = S_HI;
         end
         S_HI: begin
            cmd.op   = OP_CAP_HI;
            state_in = S_CLAMP;
         end
         S_CLAMP: begin
            cmd.op   = OP_CLAMP;
            j_in     = '0;
            q_in     = '0;
            state_in = S_RB;
         end
         S_RA: begin
            cmd.knot_addr = kidx(7'(j_ff));
            state_in      = S_RB;
         end
         S_RB: begin
            cmd.op        = OP_CAP_KA;
            cmd.knot_addr = kidx(7'(j_ff) + 7'(q_ff));
            state_in      = S_RC;
         end
         S_RC: begin
            cmd.op        = OP_CAP_KB;
            cmd.knot_addr = kidx(7'(j_ff) + 7'd1);
            state_in      = S_RD;
         end
         S_RD: begin
            cmd.op        = OP_CAP_KC;
            cmd.knot_addr = kidx(7'(j_ff) + 7'(q_ff) + 7'd1);
            state_in      = S_RE;
         end
         S_RE: begin
            cmd.op   = OP_CAP_KD;
            state_in = (q_ff == '0) ? S_LV0 : S_CLR;
         end
         S_CLR: begin
            cmd.op = OP_CLR_SUM;
            priority if (!stat.dl_zero) state_in = S_DIVL;
            else if (!stat.dr_zero)     state_in = S_DIVR;
            else                        state_in = S_STEP;
         end
         S_DIVL: begin
            cmd.op   = OP_DIV_L;
            state_in = S_WL;
         end
         S_WL: begin
            if (!stat.div_busy) begin
               cmd.op   = OP_MUL_L;
               state_in = S_AL;
            end
         end
         S_AL: begin
            cmd.op   = OP_ADD;
            state_in = stat.dr_zero ? S_STEP : S_DIVR;
         end
         S_DIVR: begin
            cmd.op   = OP_DIV_R;
            state_in = S_WR;
         end
         S_WR: begin
            if (!stat.div_busy) begin
               cmd.op   = OP_MUL_R;
               state_in = S_AR;
            end
         end
         S_AR: begin
            cmd.op   = OP_ADD;
            state_in = S_STEP;
         end
         S_LV0,
         S_STEP: begin
            cmd.op = (state_ff == S_LV0) ? OP_LVL0 : OP_STEP;
            if (last_step) begin
               j_in = '0;
               if (q_ff == p_eff) begin
                  state_in = S_PA;
               end else begin
                  q_in     = q_ff + DEG_W'(1);
                  state_in = S_RA;
               end
            end else begin
               j_in     = j_ff + BIDX_W'(1);
               state_in = S_RA;
            end
         end
         S_PA: state_in = S_PB;
         S_PB: begin
            cmd.op   = OP_WB;
            state_in = S_PC;
         end
         S_PC: begin
            cmd.op   = OP_BW;
            state_in = S_PD;
         end
         S_PD: begin
            cmd.op   = OP_PMUL;
            state_in = S_PE;
         end
         S_PE: begin
            cmd.op = OP_PACC;
            if (j_ff == BIDX_W'(n_eff - CNT_W'(1))) begin
               state_in = S_FIN;
            end else begin
               j_in     = j_ff + BIDX_W'(1);
               state_in = S_PA;
            end
         end
         S_FIN: begin
            cmd.pt_addr = '0;
            if (stat.den_pos) begin
               ax_in    = AX_X;
               state_in = S_DF;
            end else begin
               state_in = S_FB;
            end
         end
         S_FB: begin
            cmd.op       = OP_FALLBACK;
            cmd.pt_addr  = '0;
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         S_DF: begin
            cmd.op   = OP_DIV_F;
            state_in = S_WF;
         end
         S_WF: begin
            if (!stat.div_busy) begin
               cmd.op = OP_SET_F;
               unique case (ax_ff)
                  AX_X: begin
                     ax_in    = AX_Y;
                     state_in = S_DF;
                  end
                  AX_Y: begin
                     ax_in    = AX_Z;
                     state_in = S_DF;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     state_in     = S_IDLE;
                  end
               endcase
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         j_ff         <= '0;
         q_ff         <= '0;
         ax_ff        <= AX_X;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         j_ff         <= j_in;
         q_ff         <= q_in;
         ax_ff        <= ax_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         deg_ff <= DEG_W'(2);
         cnt_ff <= CNT_W'(9);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_idx_type'(csr_index))
            CSR_DEGREE: deg_ff <= csr_wdata[DEG_W-1:0];
            CSR_COUNT:  cnt_ff <= csr_wdata[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;
   assign busy      = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- design/nurbs_curve_point_eval.sv -----
`timescale 1ns / 1ps
// NURBS curve point evaluator, top level: ncpe_ctrl sequencer plus ncpe_dp datapath.
// Uses ncpe_pkg, ncpe_ctrl, ncpe_dp (and through it ncpe_div).
//
// An item is taken when start is high and busy is low. Knot and point writes
// give no result. An evaluation shows its result on rsp_data for exactly one
// cycle with rsp_valid high; the receiver cannot stall it, so it must take it
// then. Evaluation time is set by the shared one-bit-per-cycle divider: set-up
// and the degree-0 level, then per higher level 19 steps, each with up to two
// span ratios (a zero-length span skips its divide), then a pass per control
// point and three divisions for the final weighted average. With no points in
// use the result comes the next cycle.
// Config writes are accepted at any time (csr_ready is tied high) but are only
// meant while the block is idle.
module nurbs_curve_point_eval (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  ncpe_pkg::req_type      req_data,
   output logic                   rsp_valid,
   output ncpe_pkg::rsp_type      rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [0:0]             csr_index,
   input  logic [ncpe_pkg::CSR_W-1:0] csr_wdata
);
   import ncpe_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   // controller: decides what the datapath does each cycle
   ncpe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req       (req_data),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .stat      (stat)
   );

   // datapath: tables, basis triangle, weighting and the result register
   ncpe_dp u_dp (
      .clock (clock),
      .reset (reset),
      .req   (req_data),
      .cmd   (cmd),
      .stat  (stat),
      .rsp   (rsp_data)
   );

endmodule
